// ----- src/tr2c_pkg.sv -----
package tr2c_pkg;

  // field widths
  localparam int R_W   = 16;
  localparam int T_W   = 9;
  localparam int ST_W  = 2;

  // table geometry
  localparam int SEG_COUNT    = 23;
  localparam int IDX_W        = 5;
  localparam int SEARCH_STEPS = 5;
  localparam int SCNT_W       = 3;

  // table value widths (resistances up to 4280, spans up to 215 ohms)
  localparam int TR_W  = 13;
  localparam int DR_W  = 8;
  localparam int DT_W  = 4;
  localparam int P_W   = 12;
  localparam int Q_W   = 4;
  localparam int MCNT_W = 4;

  // range limits and saturated temperatures
  localparam logic [R_W-1:0] TABLE_LOW  = 16'd980;
  localparam logic [R_W-1:0] TABLE_HIGH = 16'd4280;
  localparam logic [T_W-1:0] TEMP_ABOVE = 9'd160;
  localparam logic [T_W-1:0] TEMP_BELOW = 9'h1C9;

  // range status codes
  localparam logic [ST_W-1:0] ST_IN    = 2'd0;
  localparam logic [ST_W-1:0] ST_BELOW = 2'd1;
  localparam logic [ST_W-1:0] ST_ABOVE = 2'd2;

  typedef struct packed {
    logic [TR_W-1:0] r_lo;
    logic [TR_W-1:0] r_hi;
    logic [T_W-1:0]  t_lo;
    logic [DT_W-1:0] dt;
    logic [DR_W-1:0] dr;
  } seg_t;

  // operands for the serial multiply / divide unit
  typedef struct packed {
    logic [DR_W-1:0] diff;
    logic [DT_W-1:0] dt;
    logic [DR_W-1:0] dr;
  } md_req_t;

  typedef struct packed {
    logic [Q_W-1:0] quot;
    logic           rem_nz;
  } md_res_t;

  // segment table: low/high ohms, low temperature, temperature span, ohm span
  function automatic seg_t seg_entry(input logic [IDX_W-1:0] idx);
    seg_t s;
    case (idx)
      5'd0:    s = '{13'd980,  13'd1030, -9'sd55,  4'd5,  8'd50};
      5'd1:    s = '{13'd1030, 13'd1135, -9'sd50,  4'd10, 8'd105};
      5'd2:    s = '{13'd1135, 13'd1247, -9'sd40,  4'd10, 8'd112};
      5'd3:    s = '{13'd1247, 13'd1367, -9'sd30,  4'd10, 8'd120};
      5'd4:    s = '{13'd1367, 13'd1495, -9'sd20,  4'd10, 8'd128};
      5'd5:    s = '{13'd1495, 13'd1630, -9'sd10,  4'd10, 8'd135};
      5'd6:    s = '{13'd1630, 13'd1772, 9'sd0,    4'd10, 8'd142};
      5'd7:    s = '{13'd1772, 13'd1922, 9'sd10,   4'd10, 8'd150};
      5'd8:    s = '{13'd1922, 13'd2000, 9'sd20,   4'd5,  8'd78};
      5'd9:    s = '{13'd2000, 13'd2080, 9'sd25,   4'd5,  8'd80};
      5'd10:   s = '{13'd2080, 13'd2245, 9'sd30,   4'd10, 8'd165};
      5'd11:   s = '{13'd2245, 13'd2417, 9'sd40,   4'd10, 8'd172};
      5'd12:   s = '{13'd2417, 13'd2597, 9'sd50,   4'd10, 8'd180};
      5'd13:   s = '{13'd2597, 13'd2785, 9'sd60,   4'd10, 8'd188};
      5'd14:   s = '{13'd2785, 13'd2980, 9'sd70,   4'd10, 8'd195};
      5'd15:   s = '{13'd2980, 13'd3182, 9'sd80,   4'd10, 8'd202};
      5'd16:   s = '{13'd3182, 13'd3392, 9'sd90,   4'd10, 8'd210};
      5'd17:   s = '{13'd3392, 13'd3607, 9'sd100,  4'd10, 8'd215};
      5'd18:   s = '{13'd3607, 13'd3817, 9'sd110,  4'd10, 8'd210};
      5'd19:   s = '{13'd3817, 13'd3915, 9'sd120,  4'd5,  8'd98};
      5'd20:   s = '{13'd3915, 13'd4008, 9'sd125,  4'd5,  8'd93};
      5'd21:   s = '{13'd4008, 13'd4166, 9'sd130,  4'd10, 8'd158};
      default: s = '{13'd4166, 13'd4280, 9'sd140,  4'd10, 8'd114};
    endcase
    return s;
  endfunction

endpackage

// ----- src/tr2c_seg_search.sv -----
module tr2c_seg_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [tr2c_pkg::TR_W-1:0]     r,
  output logic                          done,
  output logic [tr2c_pkg::IDX_W-1:0]    idx
);

  logic                              active;
  logic [tr2c_pkg::SCNT_W-1:0]       cnt;
  logic [tr2c_pkg::IDX_W-1:0]        lo;
  logic [tr2c_pkg::IDX_W-1:0]        hi;
  logic [tr2c_pkg::IDX_W:0]          mid_sum;
  logic [tr2c_pkg::IDX_W-1:0]        mid;
  tr2c_pkg::seg_t                    mid_seg;
  logic                              take_low;

  // probe the middle segment of the remaining interval
  always_comb begin
    mid_sum  = {1'b0, lo} + {1'b0, hi};
    mid      = mid_sum[tr2c_pkg::IDX_W:1];
    mid_seg  = tr2c_pkg::seg_entry(mid);
    take_low = (r <= mid_seg.r_hi);
  end

  // one halving step per cycle for a fixed number of steps
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == tr2c_pkg::SCNT_W'(tr2c_pkg::SEARCH_STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // interval bounds
  always_ff @(posedge clk) begin
    if (go) begin
      lo <= '0;
      hi <= tr2c_pkg::IDX_W'(tr2c_pkg::SEG_COUNT - 1);
    end else if (active) begin
      if (take_low) begin
        hi <= mid;
      end else begin
        lo <= mid + 1'b1;
      end
    end
  end

  assign idx = lo;

endmodule

// ----- src/tr2c_serial_muldiv.sv -----
module tr2c_serial_muldiv (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  tr2c_pkg::md_req_t  req,
  output logic               done,
  output tr2c_pkg::md_res_t  res
);

  logic                            active;
  logic                            div_phase;
  logic [tr2c_pkg::MCNT_W-1:0]     cnt;
  logic [tr2c_pkg::P_W-1:0]        mcand;
  logic [tr2c_pkg::DT_W-1:0]       mplier;
  logic [tr2c_pkg::P_W-1:0]        num;
  logic [tr2c_pkg::DR_W-1:0]       rem;
  logic [tr2c_pkg::DR_W-1:0]       dr;
  logic [tr2c_pkg::DR_W:0]         rem_sh;
  logic [tr2c_pkg::DR_W:0]         rem_sub;
  logic                            q_bit;

  // restoring divide step: shift in one dividend bit, try the subtract
  always_comb begin
    rem_sh  = {rem, num[tr2c_pkg::P_W-1]};
    rem_sub = rem_sh - {1'b0, dr};
    q_bit   = (rem_sh >= {1'b0, dr});
  end

  // phase sequencing: multiplier bits first, then quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      div_phase <= 1'b0;
      done      <= 1'b0;
      cnt       <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active    <= 1'b1;
        div_phase <= 1'b0;
        cnt       <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (!div_phase && cnt == tr2c_pkg::MCNT_W'(tr2c_pkg::DT_W - 1)) begin
          div_phase <= 1'b1;
          cnt       <= '0;
        end else if (div_phase && cnt == tr2c_pkg::MCNT_W'(tr2c_pkg::P_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // datapath: shift-add product into num, then divide num in place
  always_ff @(posedge clk) begin
    if (go) begin
      mcand  <= tr2c_pkg::P_W'(req.diff);
      mplier <= req.dt;
      dr     <= req.dr;
      num    <= '0;
      rem    <= '0;
    end else if (active) begin
      if (!div_phase) begin
        if (mplier[0]) begin
          num <= num + mcand;
        end
        mcand  <= {mcand[tr2c_pkg::P_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[tr2c_pkg::DT_W-1:1]};
      end else begin
        rem <= q_bit ? rem_sub[tr2c_pkg::DR_W-1:0] : rem_sh[tr2c_pkg::DR_W-1:0];
        num <= {num[tr2c_pkg::P_W-2:0], q_bit};
      end
    end
  end

  assign res.quot   = num[tr2c_pkg::Q_W-1:0];
  assign res.rem_nz = |rem;

endmodule

// ----- src/thermistor_resistance_to_celsius.sv -----
// channel   | ports                               | handshake
// ----------+-------------------------------------+-------------------------------
// input     | resistance_ohms                     | taken when start & !busy
// result    | temperature_c, range_status         | one-cycle done strobe
//
// in range, a word runs from accept to done through 5 binary-search steps over
// the segment table, then 4 multiplier bits and 12 quotient bits of the serial unit.
// out of range, done is registered in the cycle after the accept.
// a new word can be accepted in the cycle done is high.
// rst is synchronous; nothing to clear beyond the control registers.
// results cannot be held off by the receiver.
module thermistor_resistance_to_celsius (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [tr2c_pkg::R_W-1:0]    resistance_ohms,
  output logic                        done,
  output logic [tr2c_pkg::T_W-1:0]    temperature_c,
  output logic [tr2c_pkg::ST_W-1:0]   range_status
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_CALC   = 2'd2;

  logic [1:0]                      state;
  logic [1:0]                      state_next;
  logic                            accept;
  logic                            below;
  logic                            above;
  logic [tr2c_pkg::TR_W-1:0]       r_reg;
  logic [tr2c_pkg::T_W-1:0]        t_lo;
  logic                            srch_done;
  logic [tr2c_pkg::IDX_W-1:0]      srch_idx;
  tr2c_pkg::seg_t                  seg;
  tr2c_pkg::md_req_t               md_req;
  logic                            md_done;
  tr2c_pkg::md_res_t               md_res;
  logic signed [tr2c_pkg::T_W-1:0] t_floor;
  logic signed [tr2c_pkg::T_W-1:0] t_trunc;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign below  = (resistance_ohms < tr2c_pkg::TABLE_LOW);
  assign above  = (resistance_ohms > tr2c_pkg::TABLE_HIGH);

  // segment search
  tr2c_seg_search u_search (
    .clk  (clk),
    .rst  (rst),
    .go   (accept && !below && !above),
    .r    (r_reg),
    .done (srch_done),
    .idx  (srch_idx)
  );

  // operands of the chosen segment
  always_comb begin
    seg         = tr2c_pkg::seg_entry(srch_idx);
    md_req.diff = tr2c_pkg::DR_W'(r_reg - seg.r_lo);
    md_req.dt   = seg.dt;
    md_req.dr   = seg.dr;
  end

  tr2c_serial_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .go   (srch_done),
    .req  (md_req),
    .done (md_done),
    .res  (md_res)
  );

  // floor quotient plus one when a negative value has a fraction (truncate toward zero)
  always_comb begin
    t_floor = $signed(t_lo) + $signed({{(tr2c_pkg::T_W - tr2c_pkg::Q_W){1'b0}}, md_res.quot});
    t_trunc = t_floor + $signed({{(tr2c_pkg::T_W - 1){1'b0}},
                                 (t_floor[tr2c_pkg::T_W-1] && md_res.rem_nz)});
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && !below && !above) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (srch_done) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (md_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (accept && (below || above)) || (state == S_CALC && md_done);
    end
  end

  // input word, segment base temperature and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      r_reg <= resistance_ohms[tr2c_pkg::TR_W-1:0];
    end
    if (srch_done) begin
      t_lo <= seg.t_lo;
    end
    if (accept && below) begin
      temperature_c <= tr2c_pkg::TEMP_BELOW;
      range_status  <= tr2c_pkg::ST_BELOW;
    end else if (accept && above) begin
      temperature_c <= tr2c_pkg::TEMP_ABOVE;
      range_status  <= tr2c_pkg::ST_ABOVE;
    end else if (state == S_CALC && md_done) begin
      temperature_c <= t_trunc;
      range_status  <= tr2c_pkg::ST_IN;
    end
  end

endmodule
